// File: hw/rtl/assert_macros.svh
// Shared assertion macros; clk and arst_n must be visible where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define UFRM_ASSERT(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define UFRM_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/ufrm_pkg.sv
package ufrm_pkg;

	localparam int unsigned PAT_BYTES = 32;
	localparam int unsigned PAT_IDX_W = 5;
	localparam int unsigned REG_W     = 64;
	localparam int unsigned ADDR_W    = 6;

	typedef logic [PAT_BYTES-1:0][7:0] pat_bytes_t;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_LENGTH    = 3'd0;
	localparam reg_idx_t REG_WORD_A    = 3'd1;
	localparam reg_idx_t REG_WORD_B    = 3'd2;
	localparam reg_idx_t REG_WORD_C    = 3'd3;
	localparam reg_idx_t REG_WORD_D    = 3'd4;
	localparam reg_idx_t REG_ANCHOR    = 3'd5;
	localparam reg_idx_t REG_THIRD     = 3'd6;
	localparam reg_idx_t REG_TYPE_MASK = 3'd7;

	typedef logic [2:0] anchor_t;
	localparam anchor_t ANCHOR_SUBSTR = 3'd0;
	localparam anchor_t ANCHOR_START  = 3'd1;
	localparam anchor_t ANCHOR_END    = 3'd2;
	localparam anchor_t ANCHOR_EXACT  = 3'd3;
	localparam anchor_t ANCHOR_DOMAIN = 3'd4;

	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;

	typedef struct packed {
		logic [5:0] pattern_length;
		pat_bytes_t pattern;
		anchor_t    anchor_mode;
		logic       third_party_required;
		logic [7:0] type_mask;
	} ufrm_cfg_t;

	// Pattern byte at a position; positions outside the stored pattern read as zero.
	function automatic logic [7:0] pat_byte(pat_bytes_t p, int idx);
		logic [7:0] r;
		r = 8'h00;
		if (idx >= 0 && idx < int'(PAT_BYTES)) begin
			r = p[idx[PAT_IDX_W-1:0]];
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/ufrm_cfg.sv
module ufrm_cfg import ufrm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [REG_W-1:0]  pwdata,
	output logic [REG_W-1:0]  prdata,
	output logic              pready,
	output ufrm_cfg_t         cfg
);

	logic [5:0]        length_q;
	logic [3:0][63:0]  words_q;
	anchor_t           anchor_q;
	logic              third_q;
	logic [7:0]        mask_q;
	logic              wr;
	reg_idx_t          idx;

	assign wr     = psel & penable & pwrite;
	assign idx    = paddr[ADDR_W-1:3];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
			words_q  <= '0;
			anchor_q <= ANCHOR_SUBSTR;
			third_q  <= 1'b0;
			mask_q   <= 8'hFF;
		end else if (wr) begin
			unique case (idx)
				REG_LENGTH:    length_q   <= pwdata[5:0];
				REG_WORD_A:    words_q[0] <= pwdata;
				REG_WORD_B:    words_q[1] <= pwdata;
				REG_WORD_C:    words_q[2] <= pwdata;
				REG_WORD_D:    words_q[3] <= pwdata;
				REG_ANCHOR:    anchor_q   <= pwdata[2:0];
				REG_THIRD:     third_q    <= pwdata[0];
				REG_TYPE_MASK: mask_q     <= pwdata[7:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_LENGTH:    prdata = REG_W'(length_q);
			REG_WORD_A:    prdata = words_q[0];
			REG_WORD_B:    prdata = words_q[1];
			REG_WORD_C:    prdata = words_q[2];
			REG_WORD_D:    prdata = words_q[3];
			REG_ANCHOR:    prdata = REG_W'(anchor_q);
			REG_THIRD:     prdata = REG_W'(third_q);
			REG_TYPE_MASK: prdata = REG_W'(mask_q);
		endcase
	end

	assign cfg.pattern_length       = length_q;
	assign cfg.pattern              = pat_bytes_t'(words_q);
	assign cfg.anchor_mode          = anchor_q;
	assign cfg.third_party_required = third_q;
	assign cfg.type_mask            = mask_q;

endmodule

// File: hw/rtl/ufrm_cell.sv
module ufrm_cell import ufrm_pkg::*; #(
	parameter int unsigned PATTERN_MAX = 32,
	parameter int unsigned POS         = 0
) (
	input  logic                               clk,
	input  logic                               shift,
	input  logic [7:0]                         byte_in,
	input  pat_bytes_t                         pattern,
	input  logic [$clog2(PATTERN_MAX+1)-1:0]   len,
	output logic [7:0]                         byte_q,
	output logic                               ok
);

	logic       in_use;
	logic [7:0] want;

	// Window slot POS lines up with pattern byte len-1-POS.
	assign in_use = int'(len) > int'(POS);
	assign want   = pat_byte(pattern, int'(len) - int'(POS) - 1);
	assign ok     = !in_use || (byte_in == want);

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= byte_in;
		end
	end

endmodule

// File: hw/rtl/url_filter_rule_match.sv
// matched is presented in the cycle after the transfer of the last URL byte.
// Throughput: one URL byte per cycle unless an untaken result stalls url_ready; PATTERN_MAX
// window cells compare the incoming byte window against the pattern in the cycle the byte is taken.
// Reset: arst_n clears per-URL state, the result valid flag and the config registers
// (type_mask to all ones); window byte contents and the matched value are not cleared.
module url_filter_rule_match import ufrm_pkg::*; #(
	parameter int unsigned PATTERN_MAX = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              url_valid,
	output logic              url_ready,
	input  logic [7:0]        url_byte,
	input  logic              last_byte,
	input  logic              third_party,
	input  logic [2:0]        resource_type,
	output logic              match_valid,
	input  logic              match_ready,
	output logic              matched,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [REG_W-1:0]  pwdata,
	output logic [REG_W-1:0]  prdata,
	output logic              pready
);

	localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);
	localparam int unsigned CNT_W = $clog2(PATTERN_MAX + 2);

	ufrm_cfg_t              cfg;
	logic [LEN_W-1:0]       len;
	logic [7:0]             feed [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] cell_ok;
	logic                   url_fire;

	logic [CNT_W-1:0]       url_count_q, cnt_next;
	logic                   prefix_q, prefix_next;
	logic                   found_any_q, found_any_next;
	logic                   scheme_q, scheme_next;
	logic [LEN_W-1:0]       after_cnt_q, after_next;
	logic                   found_after_q, found_after_next;
	logic                   hit;
	logic                   gate_ok;
	logic                   result;
	logic                   match_valid_q;
	logic                   matched_q;

	ufrm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign url_fire = url_valid & url_ready;
	assign url_ready = !match_valid_q || match_ready;

	always_comb begin
		if (int'(cfg.pattern_length) > int'(PATTERN_MAX)) begin
			len = LEN_W'(PATTERN_MAX);
		end else begin
			len = LEN_W'(cfg.pattern_length);
		end
	end

	// Window cell row: each cell takes its neighbor's byte on every transfer.
	assign feed[0] = url_byte;
	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		if (k < PATTERN_MAX - 1) begin : g_mid
			ufrm_cell #(.PATTERN_MAX(PATTERN_MAX), .POS(k)) u_cell (
				.clk     (clk),
				.shift   (url_fire),
				.byte_in (feed[k]),
				.pattern (cfg.pattern),
				.len     (len),
				.byte_q  (feed[k+1]),
				.ok      (cell_ok[k])
			);
		end else begin : g_end
			ufrm_cell #(.PATTERN_MAX(PATTERN_MAX), .POS(k)) u_cell (
				.clk     (clk),
				.shift   (url_fire),
				.byte_in (feed[k]),
				.pattern (cfg.pattern),
				.len     (len),
				.byte_q  (),
				.ok      (cell_ok[k])
			);
		end
	end

	assign cnt_next = (url_count_q < CNT_W'(PATTERN_MAX + 1)) ?
		url_count_q + CNT_W'(1) : url_count_q;

	assign hit = (cnt_next >= CNT_W'(len)) && (len != '0) && (&cell_ok);
	assign found_any_next = found_any_q | hit;

	always_comb begin
		if (url_count_q == '0) begin
			prefix_next = (len != '0) && (url_byte == pat_byte(cfg.pattern, 0));
		end else if (url_count_q < CNT_W'(len)) begin
			prefix_next = prefix_q && (url_byte == pat_byte(cfg.pattern, int'(url_count_q)));
		end else begin
			prefix_next = prefix_q;
		end
	end

	// Track the first "://" and what is found after it.
	always_comb begin
		scheme_next      = scheme_q;
		after_next       = after_cnt_q;
		found_after_next = found_after_q;
		if (scheme_q) begin
			if (after_cnt_q < LEN_W'(PATTERN_MAX)) begin
				after_next = after_cnt_q + LEN_W'(1);
			end
			if (after_next >= len && hit) begin
				found_after_next = 1'b1;
			end
		end else if (cnt_next >= CNT_W'(3) && url_byte == CHAR_SLASH &&
			     feed[1] == CHAR_SLASH && feed[2] == CHAR_COLON) begin
			scheme_next = 1'b1;
			after_next  = '0;
		end
	end

	assign gate_ok = !(cfg.third_party_required && !third_party) &&
		cfg.type_mask[resource_type] && (len != '0);

	always_comb begin
		result = 1'b0;
		if (gate_ok) begin
			unique case (cfg.anchor_mode)
				ANCHOR_SUBSTR: result = found_any_next;
				ANCHOR_START:  result = prefix_next && (cnt_next >= CNT_W'(len));
				ANCHOR_END:    result = hit;
				ANCHOR_EXACT:  result = prefix_next && (cnt_next == CNT_W'(len));
				ANCHOR_DOMAIN: result = scheme_next ? found_after_next : found_any_next;
				default:       result = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			url_count_q   <= '0;
			prefix_q      <= 1'b0;
			found_any_q   <= 1'b0;
			scheme_q      <= 1'b0;
			after_cnt_q   <= '0;
			found_after_q <= 1'b0;
		end else if (url_fire) begin
			if (last_byte) begin
				// drop per-URL state after the last byte
				url_count_q   <= '0;
				prefix_q      <= 1'b0;
				found_any_q   <= 1'b0;
				scheme_q      <= 1'b0;
				after_cnt_q   <= '0;
				found_after_q <= 1'b0;
			end else begin
				url_count_q   <= cnt_next;
				prefix_q      <= prefix_next;
				found_any_q   <= found_any_next;
				scheme_q      <= scheme_next;
				after_cnt_q   <= after_next;
				found_after_q <= found_after_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_valid_q <= 1'b0;
		end else if (url_fire && last_byte) begin
			match_valid_q <= 1'b1;
		end else if (match_ready) begin
			match_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (url_fire && last_byte) begin
			matched_q <= result;
		end
	end

	assign match_valid = match_valid_q;
	assign matched     = matched_q;

endmodule

// File: hw/rtl/ufrm_checker.sv
`include "assert_macros.svh"

module ufrm_checker (
	input logic clk,
	input logic arst_n,
	input logic url_valid,
	input logic url_ready,
	input logic last_byte,
	input logic match_valid,
	input logic match_ready,
	input logic matched
);

	// Stalled result holds.
	`UFRM_ASSERT_NEXT(a_hold_result, match_valid && !match_ready, match_valid && $stable(matched), "result moved")
	// Every last-byte transfer yields a result in the next cycle.
	`UFRM_ASSERT_NEXT(a_last_gives_result, url_valid && url_ready && last_byte, match_valid, "no result")
	// A non-last transfer leaves no result behind.
	`UFRM_ASSERT_NEXT(a_no_spurious, url_valid && url_ready && !last_byte, !match_valid, "stray result")
	// Input side is open whenever the result register is empty.
	`UFRM_ASSERT(a_ready_when_free, !match_valid |-> url_ready, "input stalled with empty result register")

endmodule

bind url_filter_rule_match ufrm_checker u_ufrm_checker (.*);

// File: bench/url_filter_rule_match_tb.sv
`timescale 1ns / 1ps

module url_filter_rule_match_tb;
	import ufrm_pkg::*;

	typedef logic [7:0] url_bytes_t [$];

	localparam int unsigned WIN_MAX      = 32;
	localparam int unsigned RANDOM_ITEMS = 1800;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 4;

	logic              clk;
	logic              arst_n;
	logic              url_valid;
	logic              url_ready;
	logic [7:0]        url_byte;
	logic              last_byte;
	logic              third_party;
	logic [2:0]        resource_type;
	logic              match_valid;
	logic              match_ready;
	logic              matched;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [REG_W-1:0]  pwdata;
	logic [REG_W-1:0]  prdata;
	logic              pready;

	url_filter_rule_match i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.url_valid     (url_valid),
		.url_ready     (url_ready),
		.url_byte      (url_byte),
		.last_byte     (last_byte),
		.third_party   (third_party),
		.resource_type (resource_type),
		.match_valid   (match_valid),
		.match_ready   (match_ready),
		.matched       (matched),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// Rule registers as the predictor sees them
	logic [5:0] rule_len;
	logic [7:0] rule_pat [WIN_MAX];
	anchor_t    rule_anchor;
	logic       rule_third;
	logic [7:0] rule_mask;

	// Per-URL scan state
	logic [7:0] url_win [WIN_MAX];
	int         url_cnt;
	bit         prefix_ok;
	bit         seen_any;
	bit         scheme_hit;
	int         post_cnt;
	bit         seen_post;

	bit match_expect_q [$];
	bit exp_match;
	int error_count;
	int bytes_sent;
	int urls_sent;
	int rules_used;
	int match_hits;
	int cycle_count;
	bit tx_idle_en;
	bit rx_idle_en;
	int rx_stall;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic void clear_url_scan();
		url_cnt    = 0;
		prefix_ok  = 1'b0;
		seen_any   = 1'b0;
		scheme_hit = 1'b0;
		post_cnt   = 0;
		seen_post  = 1'b0;
	endfunction

	// Advance the rule scan by one URL byte; returns 1 when a verdict is due.
	function automatic bit scan_url_byte(input logic [7:0] b, input bit is_last, input bit tp,
			input logic [2:0] rt, output bit verdict);
		int  len;
		int  pos;
		bit  hit;
		len = (rule_len > WIN_MAX) ? WIN_MAX : int'(rule_len);
		pos = url_cnt;
		verdict = 1'b0;
		for (int k = WIN_MAX - 1; k > 0; k--) url_win[k] = url_win[k-1];
		url_win[0] = b;
		if (url_cnt < WIN_MAX + 1) url_cnt++;
		if (pos == 0) prefix_ok = (len > 0) && (b == rule_pat[0]);
		else if (pos < len) prefix_ok = prefix_ok && (b == rule_pat[pos]);
		hit = 1'b0;
		if (len > 0 && url_cnt >= len) begin
			hit = 1'b1;
			for (int k = 0; k < len; k++) begin
				if (url_win[k] != rule_pat[len-1-k]) hit = 1'b0;
			end
		end
		if (hit) seen_any = 1'b1;
		if (scheme_hit) begin
			if (post_cnt < WIN_MAX) post_cnt++;
			if (post_cnt >= len && hit) seen_post = 1'b1;
		end else if (url_cnt >= 3 && url_win[0] == CHAR_SLASH && url_win[1] == CHAR_SLASH &&
				url_win[2] == CHAR_COLON) begin
			scheme_hit = 1'b1;
			post_cnt   = 0;
		end
		if (!is_last) return 1'b0;
		if (!(rule_third && !tp) && rule_mask[rt] && len != 0) begin
			case (rule_anchor)
				ANCHOR_SUBSTR: verdict = seen_any;
				ANCHOR_START:  verdict = prefix_ok && url_cnt >= len;
				ANCHOR_END:    verdict = hit;
				ANCHOR_EXACT:  verdict = prefix_ok && url_cnt == len;
				ANCHOR_DOMAIN: verdict = scheme_hit ? seen_post : seen_any;
				default:       verdict = 1'b0;
			endcase
		end
		clear_url_scan();
		return 1'b1;
	endfunction

	// Receiver: draw a stall per result, then hold ready until the transfer
	always begin
		@(negedge clk);
		rx_stall = rx_idle_en ? $urandom_range(0, 4) : 0;
		if (rx_stall > 0) begin
			match_ready = 1'b0;
			repeat (rx_stall) @(negedge clk);
		end
		match_ready = 1'b1;
		do @(posedge clk); while (!match_valid);
	end

	always @(posedge clk) begin
		if (arst_n && match_valid && match_ready) begin
			if (match_expect_q.size() == 0) begin
				$error("matched: no verdict outstanding, actual %0b", matched);
				error_count++;
			end else begin
				exp_match = match_expect_q.pop_front();
				if (matched !== exp_match) begin
					$error("matched: expected %0b, actual %0b", exp_match, matched);
					error_count++;
				end
				if (exp_match) match_hits++;
			end
		end
	end

	task automatic set_reg(input reg_idx_t idx, input logic [63:0] val);
		int w;
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 3'b000};
		pwdata  = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_LENGTH:    rule_len = val[5:0];
			REG_ANCHOR:    rule_anchor = val[2:0];
			REG_THIRD:     rule_third = val[0];
			REG_TYPE_MASK: rule_mask = val[7:0];
			default: begin
				w = int'(idx) - int'(REG_WORD_A);
				for (int k = 0; k < 8; k++) rule_pat[8*w+k] = val[8*k +: 8];
			end
		endcase
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// Drop valid, then wait for every verdict and let the pipeline drain
	task automatic wait_idle();
		@(negedge clk);
		url_valid = 1'b0;
		while (match_expect_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic send_url_byte(input logic [7:0] b, input bit is_last, input bit tp,
			input logic [2:0] rt);
		int gap;
		bit verdict;
		gap = tx_idle_en ? $urandom_range(0, 4) : 0;
		@(negedge clk);
		if (gap > 0) begin
			url_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		url_byte      = b;
		last_byte     = is_last;
		third_party   = tp;
		resource_type = rt;
		url_valid     = 1'b1;
		do @(posedge clk); while (!url_ready);
		bytes_sent++;
		if (scan_url_byte(b, is_last, tp, rt, verdict)) match_expect_q = {match_expect_q, verdict};
	endtask

	// Side fields on non-final bytes are don't-care; randomize them anyway
	task automatic send_url(input url_bytes_t u, input bit tp, input logic [2:0] rt);
		for (int i = 0; i < u.size(); i++) begin
			if (i == u.size() - 1) send_url_byte(u[i], 1'b1, tp, rt);
			else send_url_byte(u[i], 1'b0, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
		end
		urls_sent++;
	endtask

	function automatic url_bytes_t text_bytes(input string s);
		url_bytes_t q;
		for (int i = 0; i < s.len(); i++) q = {q, s[i]};
		return q;
	endfunction

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 9))
			0:       return 8'($urandom_range(0, 255));
			1:       return CHAR_COLON;
			2:       return CHAR_SLASH;
			3, 4:    return rule_pat[0];
			5:       return rule_pat[1];
			default: return 8'h61 + 8'($urandom_range(0, 2));
		endcase
	endfunction

	// Mostly well-formed URLs: optional scheme, pattern copies and noise
	function automatic url_bytes_t build_url();
		url_bytes_t q;
		int len;
		int target;
		int cut;
		len = (rule_len > WIN_MAX) ? WIN_MAX : int'(rule_len);
		target = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
		if ($urandom_range(0, 4) == 0 && len > 0) begin
			for (int k = 0; k < len; k++) q = {q, rule_pat[k]};
			return q;
		end
		if ($urandom_range(0, 1) == 1) begin
			repeat ($urandom_range(0, 4)) q = {q, noise_byte()};
			q = {q, CHAR_COLON};
			q = {q, CHAR_SLASH};
			q = {q, CHAR_SLASH};
		end
		while (q.size() < target) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: for (int k = 0; k < len; k++) q = {q, rule_pat[k]};
				4: begin
					cut = (len > 0) ? $urandom_range(0, len - 1) : 0;
					for (int k = 0; k < cut; k++) q = {q, rule_pat[k]};
				end
				default: q = {q, noise_byte()};
			endcase
		end
		if (q.size() == 0) q = {q, noise_byte()};
		return q;
	endfunction

	function automatic logic [63:0] random_pattern_word();
		logic [63:0] w;
		case ($urandom_range(0, 9))
			0: w = '0;
			1: w = '1;
			default: begin
				for (int k = 0; k < 8; k++) begin
					case ($urandom_range(0, 9))
						0:       w[8*k +: 8] = 8'($urandom_range(0, 255));
						1:       w[8*k +: 8] = CHAR_COLON;
						2:       w[8*k +: 8] = CHAR_SLASH;
						default: w[8*k +: 8] = 8'h61 + 8'($urandom_range(0, 2));
					endcase
				end
			end
		endcase
		return w;
	endfunction

	task automatic program_random_rule();
		int len_val;
		int mask_val;
		case ($urandom_range(0, 19))
			0:       len_val = 0;
			1:       len_val = WIN_MAX;
			2:       len_val = $urandom_range(WIN_MAX + 1, 63);
			3:       len_val = 63;
			4, 5:    len_val = $urandom_range(9, WIN_MAX - 1);
			default: len_val = $urandom_range(1, 8);
		endcase
		case ($urandom_range(0, 9))
			0:       mask_val = 0;
			1, 2, 3: mask_val = $urandom_range(0, 255);
			default: mask_val = 255;
		endcase
		// Upper bits are don't-care for the narrow registers
		set_reg(REG_LENGTH, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_FFC0 | 64'(len_val));
		set_reg(REG_WORD_A, random_pattern_word());
		set_reg(REG_WORD_B, random_pattern_word());
		set_reg(REG_WORD_C, random_pattern_word());
		set_reg(REG_WORD_D, random_pattern_word());
		set_reg(REG_ANCHOR, 64'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 4) :
			$urandom_range(5, 7)));
		set_reg(REG_THIRD, 64'(($urandom_range(0, 3) == 0) ? 1 : 0));
		set_reg(REG_TYPE_MASK, 64'(mask_val));
		rules_used++;
	endtask

	task automatic test_reset_state();
		// Length is zero after reset: nothing matches
		send_url(text_bytes("a"), 1'b1, 3'd0);
		wait_idle();
	endtask

	task automatic test_anchor_modes();
		set_reg(REG_LENGTH, 64'd1);
		set_reg(REG_WORD_A, 64'h61);
		set_reg(REG_ANCHOR, 64'(ANCHOR_SUBSTR));
		send_url(text_bytes("ba"), 1'b0, 3'd7);
		wait_idle();
		set_reg(REG_ANCHOR, 64'(ANCHOR_START));
		send_url(text_bytes("ab"), 1'b0, 3'd0);
		wait_idle();
		set_reg(REG_ANCHOR, 64'(ANCHOR_END));
		send_url(text_bytes("ba"), 1'b1, 3'd3);
		wait_idle();
		set_reg(REG_ANCHOR, 64'(ANCHOR_EXACT));
		send_url(text_bytes("a"), 1'b0, 3'd5);
		wait_idle();
		// Pattern only before the scheme, then no scheme at all
		set_reg(REG_ANCHOR, 64'(ANCHOR_DOMAIN));
		send_url(text_bytes("a://b"), 1'b0, 3'd2);
		send_url(text_bytes("ba"), 1'b1, 3'd4);
		wait_idle();
	endtask

	task automatic test_gates();
		set_reg(REG_ANCHOR, 64'(ANCHOR_SUBSTR));
		set_reg(REG_THIRD, 64'd1);
		send_url(text_bytes("a"), 1'b0, 3'd1);
		send_url(text_bytes("a"), 1'b1, 3'd1);
		wait_idle();
		set_reg(REG_THIRD, 64'd0);
		set_reg(REG_TYPE_MASK, 64'h7F);
		send_url(text_bytes("a"), 1'b1, 3'd7);
		wait_idle();
		set_reg(REG_TYPE_MASK, 64'hFF);
		set_reg(REG_ANCHOR, 64'd7);
		send_url(text_bytes("a"), 1'b1, 3'd0);
		wait_idle();
	endtask

	task automatic test_long_pattern();
		url_bytes_t u;
		set_reg(REG_ANCHOR, 64'(ANCHOR_SUBSTR));
		set_reg(REG_LENGTH, 64'd63);
		set_reg(REG_WORD_A, '1);
		set_reg(REG_WORD_B, '1);
		set_reg(REG_WORD_C, '1);
		set_reg(REG_WORD_D, '1);
		u = '{8'h00, 8'hFF};
		send_url(u, 1'b1, 3'd6);
		wait_idle();
	endtask

	task automatic test_random_rules();
		int start;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_ITEMS) begin
			wait_idle();
			tx_idle_en = ($urandom_range(0, 3) != 0);
			rx_idle_en = ($urandom_range(0, 3) != 0);
			program_random_rule();
			repeat ($urandom_range(4, 12)) begin
				send_url(build_url(), 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
			end
		end
		wait_idle();
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		url_valid     = 1'b0;
		url_byte      = '0;
		last_byte     = 1'b0;
		third_party   = 1'b0;
		resource_type = '0;
		match_ready   = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		tx_idle_en    = 1'b1;
		rx_idle_en    = 1'b1;
		rule_len      = '0;
		rule_anchor   = ANCHOR_SUBSTR;
		rule_third    = 1'b0;
		rule_mask     = 8'hFF;
		for (int k = 0; k < WIN_MAX; k++) begin
			rule_pat[k] = '0;
			url_win[k]  = '0;
		end
		clear_url_scan();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_anchor_modes();
		test_gates();
		test_long_pattern();
		test_random_rules();

		repeat (8) @(negedge clk);
		$display("Sent %0d URLs (%0d bytes) under %0d random rule settings plus directed rules,",
			urls_sent, bytes_sent, rules_used);
		$display("all five anchor modes, gates and saturated lengths; %0d verdicts were matches.",
			match_hits);
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/ufrm_pkg.sv
hw/rtl/ufrm_cfg.sv
hw/rtl/ufrm_cell.sv
hw/rtl/url_filter_rule_match.sv
hw/rtl/ufrm_checker.sv
bench/url_filter_rule_match_tb.sv
